FILE: rtl/rwsc_pkg.sv
// Shared types and constants for the Reno window sender control block.
// No dependencies; every other file in rtl/ depends on this package.
`timescale 1ns / 1ps

package rwsc_pkg;

  localparam int unsigned SEG_W   = 25;  // segment numbers and counts
  localparam int unsigned BYTE_W  = 24;  // transfer length in bytes
  localparam int unsigned ACK_W   = 24;  // segment number carried by an ACK
  localparam int unsigned WIN_W   = 16;  // window and threshold
  localparam int unsigned SBYTE_W = 16;  // byte count of one segment
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned DUP_W   = 2;

  localparam int unsigned SEGMENT_BYTES_DEFAULT = 1024;
  localparam logic [WIN_W-1:0] INIT_THRESH_RESET = 16'd64;
  localparam logic [WIN_W-1:0] WIN_MAX           = 16'hFFFF;
  localparam logic [DUP_W-1:0] DUP_TRIGGER       = 2'd2;
  localparam logic [WIN_W-1:0] FR_INFLATE        = 16'd3;

  // Item kinds
  localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_POLL    = 2'd3;

  // Congestion phases as reported on the result
  localparam logic [PHASE_W-1:0] PHASE_SLOW  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_AVOID = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_FAST  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] total_bytes;
    logic [ACK_W-1:0]  ack_seq;
  } rwsc_in_t;

  typedef struct packed {
    logic               send_valid;
    logic [ACK_W-1:0]   send_seq;
    logic [SBYTE_W-1:0] send_bytes;
    logic [SEG_W-1:0]   window_base;
    logic [WIN_W-1:0]   window_size;
    logic [WIN_W-1:0]   threshold;
    logic [PHASE_W-1:0] phase;
    logic               finished;
  } rwsc_out_t;

endpackage

FILE: rtl/rwsc_in_if.sv
// Input event channel: valid/ready handshake carrying one event beat.
// Depends on rwsc_pkg for the payload type.
`timescale 1ns / 1ps

interface rwsc_in_if;
  logic                valid;
  logic                ready;
  rwsc_pkg::rwsc_in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rwsc_out_if.sv
// Result channel: valid/ready handshake carrying one result beat.
// Depends on rwsc_pkg for the payload type.
`timescale 1ns / 1ps

interface rwsc_out_if;
  logic                valid;
  logic                ready;
  rwsc_pkg::rwsc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rwsc_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying the threshold.
// Depends on rwsc_pkg for the data width.
`timescale 1ns / 1ps

interface rwsc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rwsc_pkg::WIN_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/reno_window_sender_control.sv
// Reno window sender control: an accepted input beat passes through the input register,
// then the update logic into the result register, to become its result beat.
// Throughput is one beat per cycle while the result side takes beats; the rate is set
// by the combinational update of the window state, which each event reads and writes.
// Reset clears both registers' valid flags, loads window 1, threshold 64,
// slow start, no transfer (finished), and the configured threshold to 64.
`timescale 1ns / 1ps

module reno_window_sender_control #(
  parameter int unsigned SEGMENT_BYTES = rwsc_pkg::SEGMENT_BYTES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rwsc_in_if.sink     in_i,
  rwsc_out_if.source  out_o,
  rwsc_cfg_if.sink    cfg_i
);
  import rwsc_pkg::*;

  // Ceiling division by the segment size is a multiply by a rounded-up
  // reciprocal: with shift SEG_W + clog2(d) it is exact for any numerator
  // below 2**SEG_W, so no correction step is needed.
  localparam int unsigned DivShift = SEG_W + $clog2(SEGMENT_BYTES);
  localparam int unsigned RecipW   = SEG_W + 1;
  localparam int unsigned ProdW    = SEG_W + RecipW;
  localparam logic [63:0] DivRecip =
    ((64'd1 << DivShift) + 64'(SEGMENT_BYTES) - 64'd1) / 64'(SEGMENT_BYTES);
  localparam logic [RecipW-1:0]  Recip    = DivRecip[RecipW-1:0];
  localparam logic [SBYTE_W-1:0] SegBytes = SBYTE_W'(SEGMENT_BYTES);
  localparam logic [SEG_W-1:0]   RoundUp  = SEG_W'(SEGMENT_BYTES - 1);

  // ---------------------------------------------------------------------------
  // Handshake and staging registers
  // ---------------------------------------------------------------------------
  rwsc_in_t   in_q;
  logic       in_valid_q;
  rwsc_out_t  out_q, out_d;
  logic       out_valid_q;
  logic       fire;        // staged event is processed this cycle
  logic       in_beat;

  assign fire      = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;
  assign in_beat   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ---------------------------------------------------------------------------
  // Window state
  // ---------------------------------------------------------------------------
  logic [WIN_W-1:0]   init_thresh_q;
  logic [WIN_W-1:0]   win_q,   win_d;
  logic [WIN_W-1:0]   thr_q,   thr_d;
  logic [PHASE_W-1:0] ph_q,    ph_d;
  logic [SEG_W-1:0]   base_q,  base_d;
  logic [SEG_W-1:0]   next_q,  next_d;
  logic [SEG_W-1:0]   stot_q,  stot_d;
  logic [BYTE_W-1:0]  btot_q,  btot_d;
  logic [SEG_W-1:0]   prev_q,  prev_d;
  logic [DUP_W-1:0]   dup_q,   dup_d;
  logic [SEG_W-1:0]   avc_q,   avc_d;
  logic               fr_q,    fr_d;

  // Segment count of a new transfer: one constant multiply
  logic [SEG_W-1:0] div_num;
  logic [ProdW-1:0] div_prod;
  logic [SEG_W-1:0] seg_count;

  assign div_num   = SEG_W'(in_q.total_bytes) + RoundUp;
  assign div_prod  = ProdW'(div_num) * ProdW'(Recip);
  assign seg_count = SEG_W'(div_prod >> DivShift);

  // Length of the final segment, low bits only: one 16x16 constant multiply
  logic [SEG_W-1:0]   stot_m1;
  logic [SBYTE_W-1:0] last_bytes;

  assign stot_m1    = stot_q - SEG_W'(1);
  assign last_bytes = btot_q[SBYTE_W-1:0] - SBYTE_W'(stot_m1[SBYTE_W-1:0] * SegBytes);

  // ---------------------------------------------------------------------------
  // Event update: each branch mirrors the order in which the state is revised
  // ---------------------------------------------------------------------------
  always_comb begin
    logic             done;
    logic [SEG_W-1:0] ack25;
    logic [SEG_W-1:0] ack_p1;
    logic [SEG_W:0]   win_sum;
    logic [SEG_W:0]   win_lim;

    win_d  = win_q;
    thr_d  = thr_q;
    ph_d   = ph_q;
    base_d = base_q;
    next_d = next_q;
    stot_d = stot_q;
    btot_d = btot_q;
    prev_d = prev_q;
    dup_d  = dup_q;
    avc_d  = avc_q;
    fr_d   = fr_q;

    out_d = '0;

    done    = base_q >= stot_q;
    ack25   = SEG_W'(in_q.ack_seq);
    ack_p1  = ack25 + SEG_W'(1);
    win_sum = '0;
    win_lim = (SEG_W+1)'(next_q) - ((SEG_W+1)'(base_q) + (SEG_W+1)'(win_q));

    unique case (in_q.mode)
      MODE_START: begin
        btot_d = in_q.total_bytes;
        stot_d = seg_count;
        win_d  = WIN_W'(1);
        thr_d  = init_thresh_q;
        ph_d   = PHASE_SLOW;
        base_d = '0;
        next_d = '0;
        prev_d = '1;
        dup_d  = '0;
        avc_d  = '0;
        fr_d   = 1'b0;
      end

      MODE_ACK: begin
        // Drop stale ACKs and anything after the transfer is done
        if (!done && !(ack_p1 < base_q)) begin
          if (prev_q != ack25) begin
            dup_d = '0;
            if (win_d >= thr_d) begin
              if (ph_d != PHASE_AVOID) begin
                avc_d = '0;
                fr_d  = 1'b1;
              end
              ph_d = PHASE_AVOID;
            end
            if (ph_d == PHASE_SLOW) begin
              avc_d   = '0;
              win_sum = (SEG_W+1)'(win_d) + (SEG_W+1)'(ack_p1 - base_q);
              win_d   = (win_sum > (SEG_W+1)'(WIN_MAX)) ? WIN_MAX : win_sum[WIN_W-1:0];
            end else if (ph_d == PHASE_AVOID) begin
              if (!fr_d) begin
                avc_d = avc_d + ack25 - prev_q;
              end
              fr_d = 1'b0;
              if (SEG_W'(win_d) == avc_d) begin
                win_d = (win_d == WIN_MAX) ? WIN_MAX : win_d + WIN_W'(1);
                avc_d = '0;
              end
            end else begin
              // Leave fast recovery: deflate to the threshold
              win_d = thr_d;
              ph_d  = PHASE_AVOID;
              avc_d = '0;
            end
            base_d = ack_p1;
          end else begin
            if (ph_d == PHASE_FAST) begin
              win_d = (win_d == WIN_MAX) ? WIN_MAX : win_d + WIN_W'(1);
              avc_d = '0;
            end else if (dup_d < DUP_TRIGGER) begin
              dup_d = dup_d + DUP_W'(1);
            end
          end
          prev_d = ack25;
          // Third identical ACK: halve, inflate and rewind
          if (dup_d == DUP_TRIGGER && ph_d != PHASE_FAST) begin
            thr_d  = win_d >> 1;
            win_d  = thr_d + FR_INFLATE;
            next_d = base_d;
            ph_d   = PHASE_FAST;
          end
        end
      end

      MODE_TIMEOUT: begin
        if (!done) begin
          next_d = base_q;
          thr_d  = win_q >> 1;
          win_d  = WIN_W'(1);
          dup_d  = '0;
          avc_d  = '0;
          ph_d   = PHASE_SLOW;
        end
      end

      MODE_POLL: begin
        // Grant when the next segment is inside the window and the transfer is not done
        if (!done && win_lim[SEG_W] && next_q < stot_q) begin
          out_d.send_valid = 1'b1;
          out_d.send_seq   = next_q[ACK_W-1:0];
          out_d.send_bytes = ((next_q + SEG_W'(1)) != stot_q) ? SegBytes : last_bytes;
          next_d           = next_q + SEG_W'(1);
        end
      end

      default: ;
    endcase

    out_d.window_base = base_d;
    out_d.window_size = win_d;
    out_d.threshold   = thr_d;
    out_d.phase       = ph_d;
    out_d.finished    = base_d >= stot_d;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      init_thresh_q <= INIT_THRESH_RESET;
      win_q         <= WIN_W'(1);
      thr_q         <= INIT_THRESH_RESET;
      ph_q          <= PHASE_SLOW;
      base_q        <= '0;
      next_q        <= '0;
      stot_q        <= '0;
      btot_q        <= '0;
      prev_q        <= '1;
      dup_q         <= '0;
      avc_q         <= '0;
      fr_q          <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        init_thresh_q <= cfg_i.data;
      end
      // Hold the staged beat until the update consumes it
      if (in_beat) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        win_q       <= win_d;
        thr_q       <= thr_d;
        ph_q        <= ph_d;
        base_q      <= base_d;
        next_q      <= next_d;
        stot_q      <= stot_d;
        btot_q      <= btot_d;
        prev_q      <= prev_d;
        dup_q       <= dup_d;
        avc_q       <= avc_d;
        fr_q        <= fr_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      in_q <= in_i.data;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_staged_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q)
    else $error("staged event beat lost before update");

  a_fire_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed event produced no result beat");

  a_grant_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.send_valid |-> !out_q.finished)
    else $error("segment granted on a finished transfer");

  a_grant_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.send_valid |-> out_q.send_bytes != '0)
    else $error("granted segment carries no bytes");

endmodule

FILE: tb/rwsc_tb_pkg.sv
// Window and congestion state tracker for the Reno sender control testbench.
// Depends on rwsc_pkg for the beat types, codes and widths.
`timescale 1ns / 1ps

package rwsc_tb_pkg;
  import rwsc_pkg::*;

  localparam int unsigned SEG_BYTES = SEGMENT_BYTES_DEFAULT;

  class window_tracker;
    logic [WIN_W-1:0]   start_thresh;
    logic [WIN_W-1:0]   win;
    logic [WIN_W-1:0]   thresh;
    logic [PHASE_W-1:0] cur_phase;
    logic [SEG_W-1:0]   base;
    logic [SEG_W-1:0]   next_seg;
    logic [SEG_W-1:0]   seg_count;
    logic [SEG_W-1:0]   last_ack;
    logic [SEG_W-1:0]   avoid_cnt;
    logic [BYTE_W-1:0]  xfer_bytes;
    logic [DUP_W-1:0]   dup_cnt;
    logic               first_round;
    rwsc_out_t          pending_reports[$];
    int unsigned        fails;

    function new();
      start_thresh = INIT_THRESH_RESET;
      win          = WIN_W'(1);
      thresh       = INIT_THRESH_RESET;
      cur_phase    = PHASE_SLOW;
      base         = '0;
      next_seg     = '0;
      seg_count    = '0;
      last_ack     = '1;
      avoid_cnt    = '0;
      xfer_bytes   = '0;
      dup_cnt      = '0;
      first_round  = 1'b0;
      fails        = 0;
    endfunction

    function logic [WIN_W-1:0] sat_win(int unsigned v);
      return (v > 32'(WIN_MAX)) ? WIN_MAX : v[WIN_W-1:0];
    endfunction

    // Advance the window state by one accepted event beat and queue its report.
    function void note_event(rwsc_in_t ev);
      rwsc_out_t        rep;
      int unsigned      ack;
      int unsigned      tail;
      logic [SEG_W-1:0] ack_seg;
      logic             done;
      rep     = '0;
      ack     = 32'(ev.ack_seq);
      ack_seg = SEG_W'(ev.ack_seq);
      done    = (base >= seg_count);
      case (ev.mode)
        MODE_START: begin
          xfer_bytes  = ev.total_bytes;
          seg_count   = SEG_W'((32'(ev.total_bytes) + SEG_BYTES - 1) / SEG_BYTES);
          win         = WIN_W'(1);
          thresh      = start_thresh;
          cur_phase   = PHASE_SLOW;
          base        = '0;
          next_seg    = '0;
          last_ack    = '1;
          dup_cnt     = '0;
          avoid_cnt   = '0;
          first_round = 1'b0;
        end
        MODE_ACK: begin
          if (!done && ack + 1 >= 32'(base)) begin
            if (32'(last_ack) != ack) begin
              dup_cnt = '0;
              if (win >= thresh) begin
                if (cur_phase != PHASE_AVOID) begin
                  avoid_cnt   = '0;
                  first_round = 1'b1;
                end
                cur_phase = PHASE_AVOID;
              end
              if (cur_phase == PHASE_SLOW) begin
                avoid_cnt = '0;
                win       = sat_win(32'(win) + ack + 1 - 32'(base));
              end else if (cur_phase == PHASE_AVOID) begin
                // the count wraps at the segment-number width
                if (!first_round) avoid_cnt = avoid_cnt + ack_seg - last_ack;
                first_round = 1'b0;
                if (32'(win) == 32'(avoid_cnt)) begin
                  win       = sat_win(32'(win) + 1);
                  avoid_cnt = '0;
                end
              end else begin
                win       = thresh;
                cur_phase = PHASE_AVOID;
                avoid_cnt = '0;
              end
              base = ack_seg + 1'b1;
            end else begin
              if (cur_phase == PHASE_FAST) begin
                win       = sat_win(32'(win) + 1);
                avoid_cnt = '0;
              end else if (dup_cnt < DUP_TRIGGER) begin
                dup_cnt = dup_cnt + 1'b1;
              end
            end
            last_ack = ack_seg;
            if (dup_cnt == DUP_TRIGGER && cur_phase != PHASE_FAST) begin
              thresh    = win >> 1;
              win       = thresh + FR_INFLATE;
              next_seg  = base;
              cur_phase = PHASE_FAST;
            end
          end
        end
        MODE_TIMEOUT: begin
          if (!done) begin
            next_seg  = base;
            thresh    = win >> 1;
            win       = WIN_W'(1);
            dup_cnt   = '0;
            avoid_cnt = '0;
            cur_phase = PHASE_SLOW;
          end
        end
        default: begin
          if (!done && 32'(next_seg) < 32'(base) + 32'(win) && next_seg < seg_count) begin
            rep.send_valid = 1'b1;
            rep.send_seq   = next_seg[ACK_W-1:0];
            if (32'(next_seg) + 1 != 32'(seg_count)) begin
              rep.send_bytes = SBYTE_W'(SEG_BYTES);
            end else begin
              tail           = 32'(xfer_bytes) - SEG_BYTES * (32'(seg_count) - 1);
              rep.send_bytes = tail[SBYTE_W-1:0];
            end
            next_seg = next_seg + 1'b1;
          end
        end
      endcase
      rep.window_base = base;
      rep.window_size = win;
      rep.threshold   = thresh;
      rep.phase       = cur_phase;
      rep.finished    = (base >= seg_count);
      pending_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(rwsc_out_t got);
      rwsc_out_t want;
      if (pending_reports.size() == 0) begin
        $error("result beat arrived with nothing expected");
        fails++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("send_valid",  32'(want.send_valid),  32'(got.send_valid));
      compare_field("send_seq",    32'(want.send_seq),    32'(got.send_seq));
      compare_field("send_bytes",  32'(want.send_bytes),  32'(got.send_bytes));
      compare_field("window_base", 32'(want.window_base), 32'(got.window_base));
      compare_field("window_size", 32'(want.window_size), 32'(got.window_size));
      compare_field("threshold",   32'(want.threshold),   32'(got.threshold));
      compare_field("phase",       32'(want.phase),       32'(got.phase));
      compare_field("finished",    32'(want.finished),    32'(got.finished));
    endfunction

    function void flag_leftovers();
      if (pending_reports.size() != 0) begin
        $error("%0d expected result beats never arrived", pending_reports.size());
        fails++;
      end
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
// Top-level testbench for reno_window_sender_control: drives event and threshold
// beats, tracks the window state alongside and checks every result beat.
// Depends on rwsc_pkg, the three channel interfaces and rwsc_tb_pkg.
`timescale 1ns / 1ps

module tb_top;
  import rwsc_pkg::*;
  import rwsc_tb_pkg::*;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rwsc_in_if  in_if ();
  rwsc_out_if out_if ();
  rwsc_cfg_if cfg_if ();

  reno_window_sender_control uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // 12 ns period: six high, six low.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  window_tracker sb = new();

  // Largest idle gap each side may draw per beat; zero gives a stretch with no idling.
  int unsigned src_max_gap = 10;
  int unsigned snk_max_gap = 10;
  // Ask the result side for one long hold-off so the block backs up into its input.
  bit          choke_req   = 1'b0;

  // Hard stop: far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Check every result beat taken at a clock edge against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  // Result side: draw a stall before every beat, or honour a long hold-off request.
  initial begin : result_sink
    int unsigned gap;
    forever begin
      if (choke_req) begin
        choke_req = 1'b0;
        gap       = 64;
      end else begin
        gap = $urandom_range(0, snk_max_gap);
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  // Offer one event beat after a random gap and hold it until taken. Valid is left
  // high on return so a back-to-back beat never sees it dropped and raised again.
  task automatic send_event(input rwsc_in_t ev);
    int unsigned gap;
    gap = $urandom_range(0, src_max_gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= ev;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    sb.note_event(ev);
  endtask

  // Write the start threshold; only ever called with the block idle.
  task automatic write_threshold(input logic [WIN_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    sb.start_thresh = value;
  endtask

  // Drop valid and hold until every expected result beat is back.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic rwsc_in_t make_event(logic [MODE_W-1:0] mode, int unsigned bytes,
                                          int unsigned ack);
    rwsc_in_t ev;
    ev.mode        = mode;
    ev.total_bytes = bytes[BYTE_W-1:0];
    ev.ack_seq     = ack[ACK_W-1:0];
    return ev;
  endfunction

  // Pick the next event from the tracked state: mostly a well-formed transfer
  // (polls and ACKs inside the flight), with duplicates, stale and far ACKs,
  // timeouts and odd restarts mixed in. Unused fields carry random bits.
  function automatic rwsc_in_t pick_event();
    rwsc_in_t    ev;
    int unsigned roll;
    int unsigned lo;
    int unsigned hi;
    ev = make_event(MODE_POLL, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
    roll = $urandom_range(0, 99);
    if (sb.base >= sb.seg_count || roll < 2) begin
      ev.mode = MODE_START;
      roll    = $urandom_range(0, 99);
      if (roll < 8)       ev.total_bytes = '0;
      else if (roll >= 14) ev.total_bytes = BYTE_W'($urandom_range(1, 24 * SEG_BYTES));
      // otherwise keep the full-width random length
    end else if (roll >= 45 && roll < 85) begin
      ev.mode = MODE_ACK;
      roll    = $urandom_range(0, 99);
      if (roll < 25 && sb.last_ack != '1) begin
        ev.ack_seq = sb.last_ack[ACK_W-1:0];
      end else if (roll >= 25 && roll < 31 && sb.base >= 2) begin
        ev.ack_seq = ACK_W'($urandom_range(0, 32'(sb.base) - 2));
      end else if (roll >= 31 && roll < 34) begin
        // keep the random segment number: usually far past the transfer
      end else begin
        lo         = 32'(sb.base);
        hi         = (sb.next_seg > sb.base) ? 32'(sb.next_seg) - 1 : 32'(sb.base);
        ev.ack_seq = ACK_W'($urandom_range(lo, hi));
      end
    end else if (roll >= 85 && roll < 90) begin
      ev.mode = MODE_TIMEOUT;
    end
    return ev;
  endfunction

  initial begin : stimulus
    logic [WIN_W-1:0] thresh_plan [6];
    int unsigned      p;
    int unsigned      k;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part, first on the reset threshold.
    // Nothing started yet: reported finished, grants nothing, ACK and timeout inert.
    send_event(make_event(MODE_POLL, 0, 0));
    send_event(make_event(MODE_ACK, 0, 0));
    send_event(make_event(MODE_TIMEOUT, 0, 0));
    // Empty transfer finishes at once.
    send_event(make_event(MODE_START, 0, 24'hFFFFFF));
    send_event(make_event(MODE_POLL, 0, 0));
    // One-byte transfer: short last segment, then a closed window, then done.
    send_event(make_event(MODE_START, 1, 0));
    send_event(make_event(MODE_POLL, 0, 0));
    send_event(make_event(MODE_POLL, 0, 0));
    send_event(make_event(MODE_ACK, 0, 0));
    send_event(make_event(MODE_ACK, 0, 0));
    // Five segments: grow, third identical ACK into fast recovery, inflate,
    // resend from the base, leave recovery, time out, stale and far ACKs.
    send_event(make_event(MODE_START, 5000, 0));
    send_event(make_event(MODE_POLL, 0, 0));
    send_event(make_event(MODE_ACK, 0, 0));
    send_event(make_event(MODE_POLL, 0, 0));
    send_event(make_event(MODE_POLL, 0, 0));
    send_event(make_event(MODE_ACK, 0, 0));
    send_event(make_event(MODE_ACK, 0, 0));
    send_event(make_event(MODE_ACK, 0, 0));
    send_event(make_event(MODE_POLL, 0, 0));
    send_event(make_event(MODE_ACK, 0, 2));
    send_event(make_event(MODE_TIMEOUT, 0, 0));
    send_event(make_event(MODE_ACK, 0, 0));
    send_event(make_event(MODE_ACK, 0, 24'hFFFFFF));
    drain_results();

    // Largest threshold and longest transfer: a far ACK saturates the window.
    write_threshold(WIN_MAX);
    send_event(make_event(MODE_START, 24'hFFFFFF, 0));
    send_event(make_event(MODE_POLL, 0, 0));
    send_event(make_event(MODE_ACK, 0, 24'hFFFFFF));
    send_event(make_event(MODE_POLL, 0, 0));
    drain_results();

    // Random part: one threshold per phase, each with one of four idling patterns.
    thresh_plan    = '{16'd1, 16'hFFFF, 16'd2, 16'd0, 16'd64, 16'd3};
    thresh_plan[3] = WIN_W'($urandom_range(1, 65535));
    for (p = 0; p < 6; p++) begin
      write_threshold(thresh_plan[p]);
      case (p % 4)
        0: begin
          src_max_gap = 10;
          snk_max_gap = 10;
        end
        1: begin
          src_max_gap = 0;
          snk_max_gap = 0;
        end
        2: begin
          // keep offering back to back while the result side holds off
          src_max_gap = 0;
          snk_max_gap = 10;
          choke_req   = 1'b1;
        end
        default: begin
          src_max_gap = 10;
          snk_max_gap = 0;
        end
      endcase
      for (k = 0; k < 100; k++) send_event(pick_event());
      drain_results();
    end

    // Wind down: bounded wait for stragglers, then the verdict.
    in_if.valid <= 1'b0;
    k = 0;
    while (sb.pending_reports.size() != 0 && k < 2000) begin
      @(posedge clk_i);
      k++;
    end
    repeat (8) @(posedge clk_i);
    sb.flag_leftovers();
    if (sb.fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
